FILE: hw/rtl/nvt_pkg.sv
// ----------------------------------------------------------------------------
// nvt_pkg
// shared constants and types of the normal vector transform pipeline
// ----------------------------------------------------------------------------
package nvt_pkg;

    localparam int VEC_WIDTH_DEF  = 16;
    localparam int COEF_WIDTH_DEF = 16;

    localparam int ROW_WIDTH  = 48;
    localparam int LANE_STEP  = 16;
    localparam int OUT_WIDTH  = 16;
    localparam int NORM_BITS  = 30;
    localparam int NORM_TOP   = 29;
    localparam int SQ_BITS    = 2 * NORM_BITS;
    localparam int SUM_BITS   = 62;
    localparam int ROOT_BITS  = 31;
    localparam int FRAC_BITS  = 14;
    localparam int QUO_BITS   = 15;
    localparam int NUM_BITS   = NORM_BITS + FRAC_BITS + 1;
    localparam int ONE_Q14    = 16384;

    localparam logic [ROW_WIDTH-1:0] ROW0_RESET = 48'h0000_0000_1000;
    localparam logic [ROW_WIDTH-1:0] ROW1_RESET = 48'h0000_1000_0000;
    localparam logic [ROW_WIDTH-1:0] ROW2_RESET = 48'h1000_0000_0000;

    localparam logic [1:0] CFG_ROW0 = 2'd0;
    localparam logic [1:0] CFG_ROW1 = 2'd1;
    localparam logic [1:0] CFG_ROW2 = 2'd2;

    typedef struct packed {
        logic       valid;
        logic       zero;
        logic [2:0] neg;
    } nvt_ctl_t;

endpackage

FILE: hw/rtl/nvt_dot.sv
// ----------------------------------------------------------------------------
// nvt_dot
// matrix times vector, products registered then summed per row
// ----------------------------------------------------------------------------
module nvt_dot #(
    parameter int VEC_WIDTH  = nvt_pkg::VEC_WIDTH_DEF,
    parameter int COEF_WIDTH = nvt_pkg::COEF_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  logic signed [VEC_WIDTH-1:0]             vec [3],
    input  logic [nvt_pkg::ROW_WIDTH-1:0]           row0,
    input  logic [nvt_pkg::ROW_WIDTH-1:0]           row1,
    input  logic [nvt_pkg::ROW_WIDTH-1:0]           row2,
    output logic                                    out_valid,
    output logic signed [VEC_WIDTH+COEF_WIDTH+1:0]  t [3]
);
    import nvt_pkg::*;

    localparam int PW = VEC_WIDTH + COEF_WIDTH;
    localparam int TW = PW + 2;

    logic [63:0]                   rows [3];
    logic signed [COEF_WIDTH-1:0]  coef [3][3];
    logic signed [PW-1:0]          prod_reg [3][3];
    logic signed [TW-1:0]          sum_reg [3];
    logic                          v1_reg;
    logic                          v2_reg;

    assign rows[0] = {16'b0, row0};
    assign rows[1] = {16'b0, row1};
    assign rows[2] = {16'b0, row2};

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            assign coef[r][c] = rows[r][LANE_STEP*c +: COEF_WIDTH];
            always_ff @(posedge clk)
            begin
                if (en)
                    prod_reg[r][c] <= coef[r][c] * vec[c];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
                sum_reg[r] <= TW'(prod_reg[r][0]) + TW'(prod_reg[r][1]) + TW'(prod_reg[r][2]);
        end
        assign t[r] = sum_reg[r];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;

endmodule

FILE: hw/rtl/nvt_norm.sv
// ----------------------------------------------------------------------------
// nvt_norm
// sign and magnitude split, leading one search, common normalizing shift
// ----------------------------------------------------------------------------
module nvt_norm #(
    parameter int VEC_WIDTH  = nvt_pkg::VEC_WIDTH_DEF,
    parameter int COEF_WIDTH = nvt_pkg::COEF_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  logic signed [VEC_WIDTH+COEF_WIDTH+1:0]  t [3],
    output nvt_pkg::nvt_ctl_t                       ctl,
    output logic [nvt_pkg::NORM_BITS-1:0]           nmag [3]
);
    import nvt_pkg::*;

    localparam int TW = VEC_WIDTH + COEF_WIDTH + 2;
    localparam int MW = VEC_WIDTH + COEF_WIDTH + 1;
    localparam int PW = $clog2(MW);

    logic [MW-1:0]         mag_reg [3];
    logic [MW-1:0]         mag2_reg [3];
    logic [MW-1:0]         or_reg;
    logic [2:0]            neg_reg;
    logic [2:0]            neg2_reg;
    logic [PW-1:0]         pos_next;
    logic [PW-1:0]         pos_reg;
    logic                  zero_reg;
    logic                  v1_reg;
    logic                  v2_reg;
    logic [TW-1:0]         neg_t [3];
    logic [MW-1:0]         mag_next [3];
    logic [NORM_BITS-1:0]  nmag_reg [3];
    nvt_ctl_t              ctl_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_abs
        assign neg_t[i]    = -t[i];
        assign mag_next[i] = t[i][TW-1] ? neg_t[i][MW-1:0] : t[i][MW-1:0];
    end

    always_comb
    begin
        pos_next = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (or_reg[i])
                pos_next = PW'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i]  <= mag_next[i];
                neg_reg[i]  <= t[i][TW-1];
                mag2_reg[i] <= mag_reg[i];
                nmag_reg[i] <= NORM_BITS'(({mag2_reg[i], {NORM_TOP{1'b0}}}) >> pos_reg);
            end
            or_reg   <= mag_next[0] | mag_next[1] | mag_next[2];
            neg2_reg <= neg_reg;
            pos_reg  <= pos_next;
            zero_reg <= (or_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            ctl_reg.valid <= v2_reg;
            ctl_reg.zero  <= zero_reg;
            ctl_reg.neg   <= neg2_reg;
        end
    end

    assign ctl  = ctl_reg;
    assign nmag = nmag_reg;

endmodule

FILE: hw/rtl/nvt_sqrt.sv
// ----------------------------------------------------------------------------
// nvt_sqrt
// squared length of the normalized vector and its integer square root,
// one root bit per pipeline stage
// ----------------------------------------------------------------------------
module nvt_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  nvt_pkg::nvt_ctl_t               in_ctl,
    input  logic [nvt_pkg::NORM_BITS-1:0]   in_mag [3],
    output nvt_pkg::nvt_ctl_t               out_ctl,
    output logic [nvt_pkg::NORM_BITS-1:0]   out_mag [3],
    output logic [nvt_pkg::ROOT_BITS-1:0]   root
);
    import nvt_pkg::*;

    logic [SQ_BITS-1:0]    sq_reg [3];
    logic [NORM_BITS-1:0]  smag_reg [3];
    nvt_ctl_t              sctl_reg;

    logic [SUM_BITS-1:0]   rem_reg  [ROOT_BITS+1];
    logic [ROOT_BITS-1:0]  root_reg [ROOT_BITS+1];
    logic [NORM_BITS-1:0]  mag_reg  [ROOT_BITS+1][3];
    nvt_ctl_t              ctl_reg  [ROOT_BITS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i]      <= SQ_BITS'(in_mag[i]) * SQ_BITS'(in_mag[i]);
                smag_reg[i]    <= in_mag[i];
                mag_reg[0][i]  <= smag_reg[i];
            end
            rem_reg[0]  <= SUM_BITS'(sq_reg[0]) + SUM_BITS'(sq_reg[1]) + SUM_BITS'(sq_reg[2]);
            root_reg[0] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sctl_reg   <= '0;
            ctl_reg[0] <= '0;
        end
        else if (en)
        begin
            sctl_reg   <= in_ctl;
            ctl_reg[0] <= sctl_reg;
        end
    end

    for (genvar k = 0; k < ROOT_BITS; k++)
    begin : g_step
        localparam int B = ROOT_BITS - 1 - k;
        logic [SUM_BITS:0] cand;
        logic              take;

        assign cand = ((SUM_BITS+1)'(root_reg[k]) << (B + 1)) | ((SUM_BITS+1)'(1) << (2 * B));
        assign take = ({1'b0, rem_reg[k]} >= cand);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= take ? rem_reg[k] - cand[SUM_BITS-1:0] : rem_reg[k];
                root_reg[k+1] <= take ? (root_reg[k] | (ROOT_BITS'(1) << B)) : root_reg[k];
                mag_reg[k+1]  <= mag_reg[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[k+1] <= '0;
            else if (en)
                ctl_reg[k+1] <= ctl_reg[k];
        end
    end

    assign out_ctl = ctl_reg[ROOT_BITS];
    assign out_mag = mag_reg[ROOT_BITS];
    assign root    = root_reg[ROOT_BITS];

endmodule

FILE: hw/rtl/nvt_div.sv
// ----------------------------------------------------------------------------
// nvt_div
// rounded division of each magnitude by the length, one quotient bit per
// stage, then saturation, sign and the output register
// ----------------------------------------------------------------------------
module nvt_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  nvt_pkg::nvt_ctl_t               in_ctl,
    input  logic [nvt_pkg::NORM_BITS-1:0]   in_mag [3],
    input  logic [nvt_pkg::ROOT_BITS-1:0]   root,
    output logic                            out_valid,
    output logic                            out_zero,
    output logic [nvt_pkg::OUT_WIDTH-1:0]   unit [3]
);
    import nvt_pkg::*;

    logic [NUM_BITS-1:0]   rem_reg  [QUO_BITS+1][3];
    logic [QUO_BITS-1:0]   quo_reg  [QUO_BITS+1][3];
    logic [ROOT_BITS-1:0]  root_reg [QUO_BITS+1];
    nvt_ctl_t              ctl_reg  [QUO_BITS+1];
    logic [OUT_WIDTH-1:0]  unit_reg [3];
    logic [OUT_WIDTH-1:0]  sat [3];
    logic                  valid_reg;
    logic                  zero_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= {1'b0, in_mag[i], {FRAC_BITS{1'b0}}} + NUM_BITS'(root >> 1);
                quo_reg[0][i] <= '0;
            end
            root_reg[0] <= root;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg[0] <= '0;
        else if (en)
            ctl_reg[0] <= in_ctl;
    end

    for (genvar k = 0; k < QUO_BITS; k++)
    begin : g_step
        localparam int B = QUO_BITS - 1 - k;
        logic [NUM_BITS:0] dsh;

        assign dsh = (NUM_BITS+1)'(root_reg[k]) << B;

        for (genvar i = 0; i < 3; i++)
        begin : g_lane
            logic take;
            assign take = ({1'b0, rem_reg[k][i]} >= dsh);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1][i] <= take ? rem_reg[k][i] - dsh[NUM_BITS-1:0] : rem_reg[k][i];
                    quo_reg[k+1][i] <= take ? (quo_reg[k][i] | (QUO_BITS'(1) << B))
                                            : quo_reg[k][i];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                root_reg[k+1] <= root_reg[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[k+1] <= '0;
            else if (en)
                ctl_reg[k+1] <= ctl_reg[k];
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_out
        assign sat[i] = (quo_reg[QUO_BITS][i] > QUO_BITS'(ONE_Q14)) ? OUT_WIDTH'(ONE_Q14)
                                                                   : OUT_WIDTH'(quo_reg[QUO_BITS][i]);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (ctl_reg[QUO_BITS].zero)
                    unit_reg[i] <= '0;
                else if (ctl_reg[QUO_BITS].neg[i])
                    unit_reg[i] <= -sat[i];
                else
                    unit_reg[i] <= sat[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            zero_reg  <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl_reg[QUO_BITS].valid;
            zero_reg  <= ctl_reg[QUO_BITS].zero;
        end
    end

    assign out_valid = valid_reg;
    assign out_zero  = zero_reg;
    assign unit      = unit_reg;

endmodule

FILE: hw/rtl/normal_vector_transform.sv
// ----------------------------------------------------------------------------
// normal_vector_transform
// from input transaction to output the pipeline runs through the matrix
// product, normalizing, the squares and the square root, and then the
// divide and output register
// throughput one vector per cycle; the whole pipeline advances together and
// holds while the output transaction waits
// asynchronous reset clears the pipeline valid bits and loads the identity
// matrix
// ----------------------------------------------------------------------------
module normal_vector_transform #(
    parameter int VEC_WIDTH  = nvt_pkg::VEC_WIDTH_DEF,
    parameter int COEF_WIDTH = nvt_pkg::COEF_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((3*VEC_WIDTH+7)/8)*8-1:0]      s_tdata,   // vec_x, vec_y, vec_z
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [3*nvt_pkg::OUT_WIDTH-1:0]       m_tdata,   // unit_x, unit_y, unit_z
    output logic                                  m_tuser,   // zero_length
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [1:0]                            cfg_index,
    input  logic [nvt_pkg::ROW_WIDTH-1:0]         cfg_data
);
    import nvt_pkg::*;

    localparam int TW = VEC_WIDTH + COEF_WIDTH + 2;

    logic [ROW_WIDTH-1:0]         row0_reg;
    logic [ROW_WIDTH-1:0]         row1_reg;
    logic [ROW_WIDTH-1:0]         row2_reg;
    logic                         en;
    logic signed [VEC_WIDTH-1:0]  vec [3];
    logic signed [TW-1:0]         t [3];
    logic                         dot_valid;
    nvt_ctl_t                     norm_ctl;
    logic [NORM_BITS-1:0]         norm_mag [3];
    nvt_ctl_t                     sqrt_ctl;
    logic [NORM_BITS-1:0]         sqrt_mag [3];
    logic [ROOT_BITS-1:0]         root;
    logic [OUT_WIDTH-1:0]         unit [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_reg <= ROW0_RESET;
            row1_reg <= ROW1_RESET;
            row2_reg <= ROW2_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ROW0: row0_reg <= cfg_data;
                CFG_ROW1: row1_reg <= cfg_data;
                CFG_ROW2: row2_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    for (genvar i = 0; i < 3; i++)
    begin : g_in
        assign vec[i] = s_tdata[i*VEC_WIDTH +: VEC_WIDTH];
    end

    nvt_dot #(
        .VEC_WIDTH  (VEC_WIDTH),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .vec       (vec),
        .row0      (row0_reg),
        .row1      (row1_reg),
        .row2      (row2_reg),
        .out_valid (dot_valid),
        .t         (t)
    );

    nvt_norm #(
        .VEC_WIDTH  (VEC_WIDTH),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (dot_valid),
        .t        (t),
        .ctl      (norm_ctl),
        .nmag     (norm_mag)
    );

    nvt_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_ctl  (norm_ctl),
        .in_mag  (norm_mag),
        .out_ctl (sqrt_ctl),
        .out_mag (sqrt_mag),
        .root    (root)
    );

    nvt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_ctl    (sqrt_ctl),
        .in_mag    (sqrt_mag),
        .root      (root),
        .out_valid (m_tvalid),
        .out_zero  (m_tuser),
        .unit      (unit)
    );

    assign m_tdata = {unit[2], unit[1], unit[0]};

    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("zero length result with nonzero data");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384)
                  && ($signed(m_tdata[15:0]) >= -16'sd16384)
                  && ($signed(m_tdata[31:16]) <= 16'sd16384)
                  && ($signed(m_tdata[31:16]) >= -16'sd16384)
                  && ($signed(m_tdata[47:32]) <= 16'sd16384)
                  && ($signed(m_tdata[47:32]) >= -16'sd16384))
        else $error("unit component beyond one");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");

endmodule
